// ----- sv/bmhpq_pkg.sv -----
// Shared types and codes for the binary max-heap priority queue.
// No dependencies; imported by every module of the block but bmhpq_ram.
`timescale 1ns / 1ps
`default_nettype none

package bmhpq_pkg;

    // Operation codes carried on the op field
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    // Controller states
    typedef enum logic [2:0] {
        CS_IDLE,
        CS_UP,
        CS_RM_RD,
        CS_DN,
        CS_RESP
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic up_step;
        logic rm_load;
        logic dn_step;
        logic out_load;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic up_stop;
        logic rm_last;
        logic dn_stop;
    } t_stat;

endpackage

`default_nettype wire

// ----- sv/bmhpq_ram.sv -----
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bmhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // write port and two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

// ----- sv/bmhpq_ctrl.sv -----
// Sequencing state machine for the heap queue: handshakes and step commands.
// Depends on bmhpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmhpq_ctrl
    import bmhpq_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire logic  i_op,
    input  wire logic  i_out_stall,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output t_cmd       o_cmd,
    input  wire t_stat i_stat
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // state and output-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= CS_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            CS_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_op == OP_INSERT) begin
                        n_state = i_stat.full ? CS_RESP : CS_UP;
                    end else begin
                        n_state = i_stat.empty ? CS_RESP : CS_RM_RD;
                    end
                end
            end
            CS_UP: begin
                o_cmd.up_step = 1'b1;
                if (i_stat.up_stop) begin
                    n_state = CS_RESP;
                end
            end
            CS_RM_RD: begin
                o_cmd.rm_load = 1'b1;
                n_state = i_stat.rm_last ? CS_RESP : CS_DN;
            end
            CS_DN: begin
                o_cmd.dn_step = 1'b1;
                if (i_stat.dn_stop) begin
                    n_state = CS_RESP;
                end
            end
            CS_RESP: begin
                // hand the word over once the output slot is free
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state = CS_IDLE;
                end
            end
            default: begin
                n_state = CS_IDLE;
            end
        endcase
    end

    assign n_out_valid = o_cmd.out_load | (r_out_valid & i_out_stall);
    assign o_in_stall  = (r_state != CS_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- sv/bmhpq_dpath.sv -----
// Heap datapath: entry RAM, held entry, position and count, sift compares.
// Depends on bmhpq_pkg and bmhpq_ram.
`timescale 1ns / 1ps
`default_nettype none

module bmhpq_dpath
    import bmhpq_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int PRIO_BITS = 16,
    parameter int TAG_BITS  = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_op,
    input  wire logic [PRIO_BITS-1:0]         i_priority_req,
    input  wire logic [TAG_BITS-1:0]          i_tag,
    input  wire t_cmd                         i_cmd,
    output t_stat                             o_stat,
    output logic      [PRIO_BITS-1:0]         o_out_priority,
    output logic      [TAG_BITS-1:0]          o_out_tag,
    output logic      [1:0]                   o_status,
    output logic      [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int W  = PRIO_BITS + TAG_BITS;
    localparam int XW = AW + 2;

    // registers
    logic [CW-1:0]        r_count;
    logic [AW-1:0]        r_pos;
    logic [PRIO_BITS-1:0] r_held_prio;
    logic [TAG_BITS-1:0]  r_held_tag;
    logic [PRIO_BITS-1:0] r_res_prio;
    logic [TAG_BITS-1:0]  r_res_tag;
    t_status              r_res_status;
    logic [PRIO_BITS-1:0] r_out_prio;
    logic [TAG_BITS-1:0]  r_out_tag;
    t_status              r_out_status;
    logic [CW-1:0]        r_out_count;

    // RAM port signals
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [W-1:0]  ram_wdata;
    logic [AW-1:0] ram_raddr_a;
    logic [AW-1:0] ram_raddr_b;
    logic [W-1:0]  ram_rdata_a;
    logic [W-1:0]  ram_rdata_b;

    // decoded read words
    logic [PRIO_BITS-1:0] rd_a_prio;
    logic [TAG_BITS-1:0]  rd_a_tag;
    logic [PRIO_BITS-1:0] rd_b_prio;
    logic [TAG_BITS-1:0]  rd_b_tag;
    logic [W-1:0]         held_word;

    // address arithmetic
    logic [CW-1:0] count_m1;
    logic [AW-1:0] last_addr;
    logic [AW-1:0] count_parent;
    logic [AW-1:0] pos_m1;
    logic [AW-1:0] pos_parent;
    logic [AW-1:0] parent_m1;
    logic [AW-1:0] pos_grand;

    // sift compares
    logic          count_full;
    logic          count_empty;
    logic          up_stop;
    logic [XW-1:0] left_idx;
    logic [XW-1:0] right_idx;
    logic [XW-1:0] count_x;
    logic          has_l;
    logic          has_r;
    logic          pick_r;
    logic [XW-1:0] ch_idx;
    logic [W-1:0]  ch_word;
    logic [PRIO_BITS-1:0] ch_prio;
    logic          dn_swap;
    logic [AW:0]   nxt_l;
    logic [AW:0]   nxt_r;

    bmhpq_ram #(
        .WIDTH (W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (ram_rdata_a),
        .o_rdata_b (ram_rdata_b)
    );

    assign rd_a_prio = ram_rdata_a[W-1:TAG_BITS];
    assign rd_a_tag  = ram_rdata_a[TAG_BITS-1:0];
    assign rd_b_prio = ram_rdata_b[W-1:TAG_BITS];
    assign rd_b_tag  = ram_rdata_b[TAG_BITS-1:0];
    assign held_word = {r_held_prio, r_held_tag};

    // parent indexes: (p - 1) / 2
    assign count_m1     = r_count - CW'(1);
    assign last_addr    = count_m1[AW-1:0];
    assign count_parent = last_addr >> 1;
    assign pos_m1       = r_pos - AW'(1);
    assign pos_parent   = pos_m1 >> 1;
    assign parent_m1    = pos_parent - AW'(1);
    assign pos_grand    = parent_m1 >> 1;

    assign count_full  = (r_count == CW'(DEPTH));
    assign count_empty = (r_count == '0);

    // sift up: move on while the held entry beats its parent
    assign up_stop = (r_pos == '0) || !(r_held_prio > rd_a_prio);

    // sift down: pick the larger child, right only when strictly larger
    assign left_idx  = {1'b0, r_pos, 1'b1};
    assign right_idx = left_idx + XW'(1);
    assign count_x   = {{(XW - CW){1'b0}}, r_count};
    assign has_l     = left_idx < count_x;
    assign has_r     = right_idx < count_x;
    assign pick_r    = has_r && (rd_b_prio > rd_a_prio);
    assign ch_idx    = pick_r ? right_idx : left_idx;
    assign ch_word   = pick_r ? ram_rdata_b : ram_rdata_a;
    assign ch_prio   = ch_word[W-1:TAG_BITS];
    assign dn_swap   = has_l && (r_held_prio < ch_prio);
    assign nxt_l     = {ch_idx[AW-1:0], 1'b1};
    assign nxt_r     = nxt_l + (AW + 1)'(1);

    // RAM port steering
    always_comb begin
        ram_we      = i_cmd.up_step | i_cmd.dn_step;
        ram_waddr   = r_pos;
        ram_wdata   = held_word;
        ram_raddr_a = '0;
        ram_raddr_b = last_addr;
        unique if (i_cmd.accept) begin
            ram_raddr_a = (i_op == OP_INSERT) ? count_parent : '0;
        end else if (i_cmd.up_step) begin
            ram_wdata   = up_stop ? held_word : ram_rdata_a;
            ram_raddr_a = pos_grand;
        end else if (i_cmd.rm_load) begin
            ram_raddr_a = AW'(1);
            ram_raddr_b = AW'(2);
        end else if (i_cmd.dn_step) begin
            ram_wdata   = dn_swap ? ch_word : held_word;
            ram_raddr_a = nxt_l[AW-1:0];
            ram_raddr_b = nxt_r[AW-1:0];
        end else begin
            ram_raddr_a = '0;
        end
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.up_step && up_stop) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.rm_load) begin
            r_count <= count_m1;
        end
    end

    // held entry, position and result words
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_held_prio <= i_priority_req;
            r_held_tag  <= i_tag;
            r_res_prio  <= '0;
            r_res_tag   <= '0;
            r_pos       <= r_count[AW-1:0];
            if (i_op == OP_INSERT) begin
                r_res_status <= count_full ? STAT_FULL : STAT_OK;
            end else begin
                r_res_status <= count_empty ? STAT_EMPTY : STAT_OK;
            end
        end
        if (i_cmd.up_step && !up_stop) begin
            r_pos <= pos_parent;
        end
        if (i_cmd.rm_load) begin
            r_res_prio  <= rd_a_prio;
            r_res_tag   <= rd_a_tag;
            r_held_prio <= rd_b_prio;
            r_held_tag  <= rd_b_tag;
            r_pos       <= '0;
        end
        if (i_cmd.dn_step && dn_swap) begin
            r_pos <= ch_idx[AW-1:0];
        end
        if (i_cmd.out_load) begin
            r_out_prio   <= r_res_prio;
            r_out_tag    <= r_res_tag;
            r_out_status <= r_res_status;
            r_out_count  <= r_count;
        end
    end

    assign o_stat.full    = count_full;
    assign o_stat.empty   = count_empty;
    assign o_stat.up_stop = up_stop;
    assign o_stat.rm_last = (r_count == CW'(1));
    assign o_stat.dn_stop = !dn_swap;

    assign o_out_priority = r_out_prio;
    assign o_out_tag      = r_out_tag;
    assign o_status       = r_out_status;
    assign o_count        = r_out_count;

endmodule

`default_nettype wire

// ----- sv/binary_max_heap_priority_queue_core.sv -----
// Bounded max-priority queue held as a binary heap in one RAM.
//
// Input channel: i_in_valid / o_in_stall carry one word per operation:
// i_op (insert or remove), i_priority_req and i_tag. Output channel:
// o_out_valid / i_out_stall carry one result word per operation:
// removed priority and tag, status (done, insert on full, remove on
// empty) and the entry count after the operation.
// After acceptance, an insert sifts up one heap level per step (CS_UP)
// while the held entry beats its parent; a remove first loads root and
// last (CS_RM_RD), then sifts down one level per step (CS_DN) unless it
// took the only entry; a full insert or empty remove goes straight to
// the result state (CS_RESP). One word is handled at a time; the next is
// taken the cycle after the result is registered. Each sift step is
// paced by the RAM's registered read (the compare of one level overlaps
// the read of the next).
// Synchronous active-low reset empties the queue and clears output
// valid; the RAM is not cleared. While the receiver stalls, the result
// word holds and a finished operation waits for the output slot.
// Depends on bmhpq_pkg, bmhpq_ctrl, bmhpq_dpath and bmhpq_ram.
`timescale 1ns / 1ps
`default_nettype none

module binary_max_heap_priority_queue_core
    import bmhpq_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int PRIO_BITS = 16,
    parameter int TAG_BITS  = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic                       i_op,
    input  wire logic [PRIO_BITS-1:0]       i_priority_req,
    input  wire logic [TAG_BITS-1:0]        i_tag,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic      [PRIO_BITS-1:0]       o_out_priority,
    output logic      [TAG_BITS-1:0]        o_out_tag,
    output logic      [1:0]                 o_status,
    output logic      [$clog2(DEPTH+1)-1:0] o_count
);

    t_cmd  cmd;
    t_stat stat;

    bmhpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_op),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    bmhpq_dpath #(
        .DEPTH     (DEPTH),
        .PRIO_BITS (PRIO_BITS),
        .TAG_BITS  (TAG_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (i_op),
        .i_priority_req (i_priority_req),
        .i_tag          (i_tag),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_out_priority (o_out_priority),
        .o_out_tag      (o_out_tag),
        .o_status       (o_status),
        .o_count        (o_count)
    );

endmodule

`default_nettype wire

// ----- sv/bmhpq_checker.sv -----
// Port-level checks for the heap queue, bound to the top level.
// Depends on bmhpq_pkg and binary_max_heap_priority_queue_core.
`timescale 1ns / 1ps
`default_nettype none

module bmhpq_checker
    import bmhpq_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int PRIO_BITS = 16,
    parameter int TAG_BITS  = 16
) (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       o_in_stall,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_stall,
    input wire logic [PRIO_BITS-1:0]       o_out_priority,
    input wire logic [TAG_BITS-1:0]        o_out_tag,
    input wire logic [1:0]                 o_status,
    input wire logic [$clog2(DEPTH+1)-1:0] o_count
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_priority)
            && $stable(o_out_tag) && $stable(o_status) && $stable(o_count))
        else $error("result word changed while stalled");

    // one word in flight: busy right after acceptance
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again while an operation is in flight");

    // a dropped insert reports a full queue
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == STAT_FULL) |-> (o_count == DEPTH))
        else $error("full status with queue not full");

    // an empty remove returns a zero word and an empty queue
    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == STAT_EMPTY) |->
            (o_count == '0) && (o_out_priority == '0) && (o_out_tag == '0))
        else $error("empty status with non-zero word or count");

endmodule

bind binary_max_heap_priority_queue_core bmhpq_checker #(
    .DEPTH     (DEPTH),
    .PRIO_BITS (PRIO_BITS),
    .TAG_BITS  (TAG_BITS)
) u_bmhpq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_out_priority (o_out_priority),
    .o_out_tag      (o_out_tag),
    .o_status       (o_status),
    .o_count        (o_count)
);

`default_nettype wire
